@@ rtl/stgv_pkg.sv @@
// ----------------------------------------------------------------------------
// stgv_pkg
// Shared widths, reset values, codes and small tables for the square tone
// generator with vibrato.
// ----------------------------------------------------------------------------
`default_nettype none

package stgv_pkg;

    localparam int PHASE_BITS_DEF   = 32;
    localparam int SINE_ENTRIES_DEF = 256;

    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int OFFSET_W   = 6;
    localparam int SAMPLE_W   = 8;
    localparam int TDATA_W    = 8;
    localparam int SINE_W     = 16;
    localparam int RATE_W     = CFG_W + 2;
    localparam int MUL_A_W    = CFG_W + 1;
    localparam int MUL_B_W    = 17;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int SINE_FRAC  = 15;
    localparam int SHAMT_W    = 5;

    localparam logic [CFG_W-1:0] BASE_STEP_RST  = 32'd42949673;
    localparam logic [CFG_W-1:0] DEPTH_STEP_RST = 32'd973916;
    localparam logic [CFG_W-1:0] LFO_STEP_RST   = 32'd486958;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_STEP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LFO_STEP   = 2'd2;

    localparam logic [SAMPLE_W-1:0] SAMPLE_HIGH = 8'd255;
    localparam logic [SAMPLE_W-1:0] SAMPLE_LOW  = 8'd1;

    localparam longint HALF_PI_Q30 = 64'd1686629713;

    // Right shift applied to the scaled step is this value minus the
    // biased octave (octave plus three).
    localparam logic [SHAMT_W-1:0] SHIFT_TOP = 5'd19;

    typedef struct packed {
        logic [2:0] oct_idx;
        logic [3:0] semi;
    } oct_split_t;

    // Splits a signed semitone offset into a biased octave and a semitone
    // within the octave, rounding the octave towards minus infinity.
    function automatic oct_split_t split_offset(input logic [OFFSET_W-1:0] s);
        logic [6:0] u;
        oct_split_t r;
        u = 7'({s[OFFSET_W-1], s}) + 7'd36;
        if (u >= 7'd60)
            r.oct_idx = 3'd5;
        else if (u >= 7'd48)
            r.oct_idx = 3'd4;
        else if (u >= 7'd36)
            r.oct_idx = 3'd3;
        else if (u >= 7'd24)
            r.oct_idx = 3'd2;
        else if (u >= 7'd12)
            r.oct_idx = 3'd1;
        else
            r.oct_idx = 3'd0;
        r.semi = 4'(u - 7'(12 * r.oct_idx));
        return r;
    endfunction

    // Frequency ratio of a semitone within the octave, Q16.
    function automatic logic [MUL_B_W-1:0] semi_ratio(input logic [3:0] k);
        logic [MUL_B_W-1:0] r;
        case (k)
            4'd0:    r = 17'd65536;
            4'd1:    r = 17'd69433;
            4'd2:    r = 17'd73562;
            4'd3:    r = 17'd77936;
            4'd4:    r = 17'd82570;
            4'd5:    r = 17'd87480;
            4'd6:    r = 17'd92682;
            4'd7:    r = 17'd98193;
            4'd8:    r = 17'd104033;
            4'd9:    r = 17'd110218;
            4'd10:   r = 17'd116772;
            4'd11:   r = 17'd123715;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/stgv_mul.sv @@
// ----------------------------------------------------------------------------
// stgv_mul
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle, most
// significant bit first.
// ----------------------------------------------------------------------------
`default_nettype none

module stgv_mul import stgv_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [MUL_A_W-1:0] a,
    input  wire logic [MUL_B_W-1:0] b,
    output logic                    done,
    output logic [PROD_W-1:0]       product
);

    localparam int CNT_W = $clog2(MUL_B_W + 1);

    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               done_reg;
    logic               done_next;
    logic [MUL_A_W-1:0] a_reg;
    logic [MUL_B_W-1:0] b_reg;
    logic [MUL_B_W-1:0] b_next;
    logic [PROD_W-1:0]  acc_reg;
    logic [PROD_W-1:0]  acc_next;

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            cnt_next = CNT_W'(MUL_B_W);
            b_next   = b;
            acc_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
            b_next    = {b_reg[MUL_B_W-2:0], 1'b0};
            acc_next  = {acc_reg[PROD_W-2:0], 1'b0}
                      + (b_reg[MUL_B_W-1] ? PROD_W'(a_reg) : '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            a_reg <= a;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

@@ rtl/square_tone_generator_with_vibrato.sv @@
// ----------------------------------------------------------------------------
// square_tone_generator_with_vibrato
// Square-wave oscillator whose pitch is bent by a sine vibrato and by a
// signed semitone offset carried on each sample request.
//
//  Channel  Direction  Handshake          Payload
//  s_*      in         tvalid / tready    tdata[5:0] semitone offset
//  m_*      out        tvalid / tready    tdata[7:0] sample
//  cfg_*    in         cfg_valid / ready  cfg_index, cfg_data
//
// A new request can be taken only once the phase update for the last one is done,
// which runs two passes of the shared bit-serial multiplier over its 17-bit operand.
// The sample is registered at acceptance, so the output can be taken while
// the phase update is still running; a stalled output holds the next request.
// Reset clears both phases and loads the default step registers.
// Configuration writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none

module square_tone_generator_with_vibrato import stgv_pkg::*;
#(
    parameter int PHASE_BITS         = PHASE_BITS_DEF,
    parameter int SINE_TABLE_ENTRIES = SINE_ENTRIES_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [TDATA_W-1:0]   s_tdata,   // [5:0] semitone_offset
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [TDATA_W-1:0]        m_tdata,   // [7:0] sample
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int SINE_IDX_W = $clog2(SINE_TABLE_ENTRIES);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SINE = 3'd1;
    localparam logic [2:0] S_MUL1 = 3'd2;
    localparam logic [2:0] S_RATE = 3'd3;
    localparam logic [2:0] S_MUL2 = 3'd4;

    logic [2:0]            state_reg;
    logic [2:0]            state_next;
    logic [CFG_W-1:0]      base_step_reg;
    logic [CFG_W-1:0]      depth_step_reg;
    logic [CFG_W-1:0]      lfo_step_reg;
    logic [PHASE_BITS-1:0] tone_phase_reg;
    logic [PHASE_BITS-1:0] tone_phase_next;
    logic [PHASE_BITS-1:0] lfo_phase_reg;
    logic [PHASE_BITS-1:0] lfo_phase_next;
    logic                  m_tvalid_reg;
    logic                  m_tvalid_next;
    logic [SAMPLE_W-1:0]   sample_reg;
    oct_split_t            split_reg;
    logic                  sine_neg_reg;
    logic signed [RATE_W-1:0] rate_reg;
    logic                  rate_neg_reg;

    logic signed [SINE_W-1:0] sine_rom [SINE_TABLE_ENTRIES];
    logic signed [SINE_W-1:0] sine_reg;

    logic                  accept;
    logic                  mul_start;
    logic [MUL_A_W-1:0]    mul_a;
    logic [MUL_B_W-1:0]    mul_b;
    logic                  mul_done;
    logic [PROD_W-1:0]     mul_prod;
    logic [SINE_W-1:0]     sine_abs;
    logic [RATE_W-1:0]     dev_mag;
    logic signed [RATE_W-1:0] rate_next;
    logic [RATE_W-1:0]     rate_abs;
    logic [SHAMT_W-1:0]    shamt;
    logic [PROD_W-1:0]     scaled;
    logic [PHASE_BITS-1:0] step;

    for (genvar gi = 0; gi < SINE_TABLE_ENTRIES; gi++)
    begin : g_sine
        localparam longint Four   = longint'(gi) * 4;
        localparam longint Quad   = Four / SINE_TABLE_ENTRIES;
        localparam longint RemA   = Four - Quad * SINE_TABLE_ENTRIES;
        localparam longint Rem    = (Quad % 2 == 1) ? SINE_TABLE_ENTRIES - RemA : RemA;
        localparam longint Theta  = Rem * HALF_PI_Q30 / SINE_TABLE_ENTRIES;
        localparam longint Theta2 = (Theta * Theta) >>> 30;
        localparam longint T1     = ((Theta * Theta2) >>> 30) / 6;
        localparam longint T2     = ((T1 * Theta2) >>> 30) / 20;
        localparam longint T3     = ((T2 * Theta2) >>> 30) / 42;
        localparam longint T4     = ((T3 * Theta2) >>> 30) / 72;
        localparam longint T5     = ((T4 * Theta2) >>> 30) / 110;
        localparam longint T6     = ((T5 * Theta2) >>> 30) / 156;
        localparam longint Sum    = Theta - T1 + T2 - T3 + T4 - T5 + T6;
        localparam longint SumC   = (Sum < 0) ? 0 : Sum;
        localparam longint Mag0   = (SumC * 32767 + (longint'(1) <<< 29)) >>> 30;
        localparam longint Mag    = (Mag0 > 32767) ? 32767 : Mag0;
        localparam longint Val    = (Quad >= 2) ? -Mag : Mag;
        assign sine_rom[gi] = SINE_W'(Val);
    end

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE) && (!m_tvalid_reg || m_tready);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = sample_reg;
    assign cfg_ready = 1'b1;

    assign sine_abs  = sine_reg[SINE_W-1] ? SINE_W'(-sine_reg) : SINE_W'(sine_reg);
    assign dev_mag   = RATE_W'(mul_prod >> SINE_FRAC);
    assign rate_next = sine_neg_reg ? $signed(RATE_W'(base_step_reg) - dev_mag)
                                    : $signed(RATE_W'(base_step_reg) + dev_mag);
    assign rate_abs  = rate_reg[RATE_W-1] ? RATE_W'(-rate_reg) : RATE_W'(rate_reg);

    assign mul_start = (state_reg == S_SINE) || (state_reg == S_RATE);
    assign mul_a     = (state_reg == S_SINE) ? MUL_A_W'(depth_step_reg)
                                             : MUL_A_W'(rate_abs);
    assign mul_b     = (state_reg == S_SINE) ? MUL_B_W'(sine_abs)
                                             : semi_ratio(split_reg.semi);

    assign shamt     = SHIFT_TOP - SHAMT_W'(split_reg.oct_idx);
    assign scaled    = mul_prod >> shamt;
    assign step      = PHASE_BITS'(scaled);

    stgv_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    always_comb
    begin
        state_next      = state_reg;
        tone_phase_next = tone_phase_reg;
        lfo_phase_next  = lfo_phase_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        if (accept)
            m_tvalid_next = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next     = S_SINE;
                    lfo_phase_next = lfo_phase_reg + PHASE_BITS'(lfo_step_reg);
                end
            end
            S_SINE:
                state_next = S_MUL1;
            S_MUL1:
            begin
                if (mul_done)
                    state_next = S_RATE;
            end
            S_RATE:
                state_next = S_MUL2;
            S_MUL2:
            begin
                if (mul_done)
                begin
                    state_next      = S_IDLE;
                    tone_phase_next = rate_neg_reg ? tone_phase_reg - step
                                                   : tone_phase_reg + step;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tone_phase_reg <= '0;
            lfo_phase_reg  <= '0;
            m_tvalid_reg   <= 1'b0;
            base_step_reg  <= BASE_STEP_RST;
            depth_step_reg <= DEPTH_STEP_RST;
            lfo_step_reg   <= LFO_STEP_RST;
        end
        else
        begin
            state_reg      <= state_next;
            tone_phase_reg <= tone_phase_next;
            lfo_phase_reg  <= lfo_phase_next;
            m_tvalid_reg   <= m_tvalid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_BASE_STEP:  base_step_reg  <= cfg_data;
                    CFG_DEPTH_STEP: depth_step_reg <= cfg_data;
                    CFG_LFO_STEP:   lfo_step_reg   <= cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sine_reg <= sine_rom[lfo_phase_reg[PHASE_BITS-1 -: SINE_IDX_W]];
        if (accept)
        begin
            sample_reg <= tone_phase_reg[PHASE_BITS-1] ? SAMPLE_LOW : SAMPLE_HIGH;
            split_reg  <= split_offset(s_tdata[OFFSET_W-1:0]);
        end
        if (state_reg == S_SINE)
            sine_neg_reg <= sine_reg[SINE_W-1];
        if (state_reg == S_MUL1 && mul_done)
            rate_reg <= rate_next;
        if (state_reg == S_RATE)
            rate_neg_reg <= rate_reg[RATE_W-1];
    end

    a_lfo_only_on_request: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(lfo_phase_reg))
        else $error("vibrato phase moved without a request");

    a_tone_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg == S_MUL2 && mul_done) |=> $stable(tone_phase_reg))
        else $error("tone phase moved outside the update step");

    a_sample_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid && state_reg == S_SINE)
        else $error("request did not present a sample and start the update");

    a_mul_not_restarted: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SINE || state_reg == S_RATE) |=> !mul_done)
        else $error("multiplier finished right after being started");

endmodule

`default_nettype wire
